// File: hdl/bfb_pkg.sv
// Shared types and constants for the block frame builder.
package bfb_pkg;

    // command queue depth between front and back end
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    // one classified payload item, as handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] blk;
        logic [15:0] len;     // saturated block length
        logic        first;
        logic        last;
    } cmd_t;

endpackage

// File: hdl/block_frame_builder_crc16.sv
// Block frame builder: frames payload blocks with a header and CRC-16.
//
// Usage: payload bytes enter on the s_ channel (valid/ready), one item per
// byte, with block_index and payload_length sampled on the first byte of a
// block. Framed packet bytes leave on the m_ channel (valid/ready); the high
// CRC byte carries end_of_frame. total_blocks is written through cfg_wr_en/
// cfg_wr_data, only while the block is idle; the user must ensure this.
// Throughput: one output byte per cycle while an item is queued and the
// receiver is ready. A mid-block payload item emits one byte, a first item
// 14 bytes (13 header bytes plus the byte), a last item 3 bytes (the byte
// plus two CRC bytes); the output byte sequencer sets this. Input items are
// taken every cycle while the 4-entry command queue has room, so header and
// CRC bursts are absorbed there. An accepted item passes through the queue
// and then the output register before its first byte leaves on m_.
// Reset (aresetn low, synchronous) clears the frame state, the queue, the
// output valid flag and total_blocks. When the receiver stalls the output
// register holds its byte, the queue fills and then s_ready drops.
module block_frame_builder_crc16 #(
    parameter int unsigned MAX_BLOCK_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic [15:0] s_block_index,
    input  logic [10:0] s_payload_length,
    input  logic        s_first_of_block,
    input  logic        s_last_of_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_end_of_frame
);

    logic [15:0]   total_blocks_reg;
    logic          q_full;
    logic          q_push;
    bfb_pkg::cmd_t q_cmd;
    logic          q_pop;
    logic          head_valid;
    bfb_pkg::cmd_t head_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_blocks_reg <= '0;
        end else if (cfg_wr_en) begin
            total_blocks_reg <= cfg_wr_data;
        end
    end

    bfb_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_payload_byte   (s_payload_byte),
        .s_block_index    (s_block_index),
        .s_payload_length (s_payload_length),
        .s_first_of_block (s_first_of_block),
        .s_last_of_block  (s_last_of_block),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (q_cmd)
    );

    bfb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    bfb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .total_blocks   (total_blocks_reg),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_byte   (m_frame_byte),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule

// File: hdl/bfb_front.sv
// Front end: accepts input items, tracks frame state, queues commands.
module bfb_front #(
    parameter int unsigned MAX_BLOCK_BYTES = 1024
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_payload_byte,
    input  logic [15:0]   s_block_index,
    input  logic [10:0]   s_payload_length,
    input  logic          s_first_of_block,
    input  logic          s_last_of_block,
    input  logic          q_full,
    output logic          q_push,
    output bfb_pkg::cmd_t q_cmd
);

    localparam logic [15:0] MaxLen = 16'(MAX_BLOCK_BYTES);

    logic        in_frame_reg;
    logic        in_frame_next;
    logic        accept;
    logic [15:0] len_ext;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign len_ext = {5'b0, s_payload_length};

    always_comb begin
        q_cmd.data  = s_payload_byte;
        q_cmd.blk   = s_block_index;
        q_cmd.len   = (len_ext > MaxLen) ? MaxLen : len_ext;
        q_cmd.first = s_first_of_block;
        q_cmd.last  = s_last_of_block;
    end

    // items outside an open frame are dropped
    assign q_push = accept && (s_first_of_block || in_frame_reg);

    always_comb begin
        in_frame_next = in_frame_reg;
        if (q_push) begin
            in_frame_next = !s_last_of_block;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// File: hdl/bfb_queue.sv
// Short command queue between front and back end.
module bfb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bfb_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output bfb_pkg::cmd_t head_cmd
);

    localparam int unsigned CNT_W = $clog2(bfb_pkg::QDEPTH + 1);

    bfb_pkg::cmd_t                  mem_reg [bfb_pkg::QDEPTH];
    logic [bfb_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [bfb_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full       = (count_reg == CNT_W'(bfb_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + bfb_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + bfb_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// File: hdl/bfb_back.sv
// Back end: sequences header, payload and CRC bytes into the output register.
module bfb_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [15:0]   total_blocks,
    input  logic          head_valid,
    input  bfb_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_frame_byte,
    output logic          m_end_of_frame
);

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [3:0] POS_SYNC0   = 4'd0;
    localparam logic [3:0] POS_SYNC1   = 4'd1;
    localparam logic [3:0] POS_SYNC2   = 4'd2;
    localparam logic [3:0] POS_MLEN_LO = 4'd3;
    localparam logic [3:0] POS_MLEN_HI = 4'd4;
    localparam logic [3:0] POS_CMD     = 4'd5;
    localparam logic [3:0] POS_TYPE    = 4'd6;
    localparam logic [3:0] POS_TOT_LO  = 4'd7;
    localparam logic [3:0] POS_TOT_HI  = 4'd8;
    localparam logic [3:0] POS_BLK_LO  = 4'd9;
    localparam logic [3:0] POS_BLK_HI  = 4'd10;
    localparam logic [3:0] POS_LEN_LO  = 4'd11;
    localparam logic [3:0] POS_LEN_HI  = 4'd12;
    localparam logic [3:0] POS_PAYLOAD = 4'd13;
    localparam logic [3:0] POS_CRC_LO  = 4'd14;
    localparam logic [3:0] POS_CRC_HI  = 4'd15;

    localparam logic [7:0] SYNC0_BYTE = 8'hf8;
    localparam logic [7:0] SYNC1_BYTE = 8'h55;
    localparam logic [7:0] SYNC2_BYTE = 8'hce;
    localparam logic [7:0] CMD_BYTE   = 8'h82;
    localparam logic [7:0] TYPE_BYTE  = 8'h01;

    // augmented byte-wise CRC step
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] din);
        logic [15:0] acc;
        logic [15:0] hi;
        acc = '0;
        hi  = {crc[15:8], 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (hi[15] ^ acc[15]) begin
                acc = {acc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[14:0], 1'b0};
            end
            hi = {hi[14:0], 1'b0};
        end
        return acc ^ {crc[7:0], 8'h00} ^ {8'h00, din};
    endfunction

    logic        busy_reg;
    logic [3:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        m_valid_reg;
    logic [7:0]  m_byte_reg;
    logic        m_eof_reg;

    logic [3:0]  pos;
    logic        emit;
    logic        done;
    logic [7:0]  byte_sel;
    logic [15:0] mlen;
    logic [15:0] crc_next;

    assign pos  = busy_reg ? idx_reg : (head_cmd.first ? POS_SYNC0 : POS_PAYLOAD);
    assign emit = head_valid && (!m_valid_reg || m_ready);
    assign mlen = head_cmd.len + 16'd8;
    assign done = (pos == POS_CRC_HI) || ((pos == POS_PAYLOAD) && !head_cmd.last);
    assign pop  = emit && done;

    always_comb begin
        unique case (pos)
            POS_SYNC0:   byte_sel = SYNC0_BYTE;
            POS_SYNC1:   byte_sel = SYNC1_BYTE;
            POS_SYNC2:   byte_sel = SYNC2_BYTE;
            POS_MLEN_LO: byte_sel = mlen[7:0];
            POS_MLEN_HI: byte_sel = mlen[15:8];
            POS_CMD:     byte_sel = CMD_BYTE;
            POS_TYPE:    byte_sel = TYPE_BYTE;
            POS_TOT_LO:  byte_sel = total_blocks[7:0];
            POS_TOT_HI:  byte_sel = total_blocks[15:8];
            POS_BLK_LO:  byte_sel = head_cmd.blk[7:0];
            POS_BLK_HI:  byte_sel = head_cmd.blk[15:8];
            POS_LEN_LO:  byte_sel = head_cmd.len[7:0];
            POS_LEN_HI:  byte_sel = head_cmd.len[15:8];
            POS_PAYLOAD: byte_sel = head_cmd.data;
            POS_CRC_LO:  byte_sel = crc_reg[7:0];
            default:     byte_sel = crc_reg[15:8];
        endcase
    end

    // CRC restarts with the header and covers the command byte through payload
    always_comb begin
        crc_next = crc_reg;
        if (pos == POS_SYNC0) begin
            crc_next = '0;
        end else if (pos >= POS_CMD && pos <= POS_PAYLOAD) begin
            crc_next = crc_feed(crc_reg, byte_sel);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg <= byte_sel;
            m_eof_reg  <= (pos == POS_CRC_HI);
            crc_reg    <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= POS_SYNC0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
                busy_reg    <= !done;
                idx_reg     <= pos + 4'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_byte   = m_byte_reg;
    assign m_end_of_frame = m_eof_reg;

    a_crc_hi_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && pos == POS_CRC_LO) |=> (busy_reg && idx_reg == POS_CRC_HI))
        else $error("CRC low byte not followed by high byte");

    a_busy_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> head_valid)
        else $error("sequencer busy without a queued item");

endmodule
